// ===== sv/atm_pkg.sv =====
// ----------------------------------------------------------------------------
// atm_pkg
// shared widths, constants and types of the burst trimmed-mean block
// ----------------------------------------------------------------------------
`default_nettype none

package atm_pkg;

	// field and state widths
	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 17;
	localparam int POS_W    = 5;

	// samples in one burst
	localparam int BURST_LEN = 20;

	// largest sample code, also the reset value of the running minimum
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

	// result of the burst stage for the item in flight
	typedef struct packed {
		logic                done;
		logic [SAMPLE_W-1:0] average;
	} burst_res_t;

endpackage

`default_nettype wire

// ===== sv/atm_burst.sv =====
// ----------------------------------------------------------------------------
// atm_burst
// burst state (position, sum, max, min) and the trimmed average on the last
// sample of a burst
// ----------------------------------------------------------------------------
`default_nettype none

module atm_burst #(
	parameter int SETTLE_SAMPLES = 2,
	parameter int AVERAGE_SHIFT  = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic [atm_pkg::SAMPLE_W-1:0] sample,
	output atm_pkg::burst_res_t               res
);

	logic [atm_pkg::POS_W-1:0]    position_q;
	logic [atm_pkg::SUM_W-1:0]    sum_q;
	logic [atm_pkg::SAMPLE_W-1:0] largest_q;
	logic [atm_pkg::SAMPLE_W-1:0] smallest_q;

	logic                         kept;
	logic                         last;
	logic [atm_pkg::SUM_W-1:0]    sum_n;
	logic [atm_pkg::SAMPLE_W-1:0] largest_n;
	logic [atm_pkg::SAMPLE_W-1:0] smallest_n;
	logic [atm_pkg::SUM_W-1:0]    extremes;
	logic [atm_pkg::SUM_W-1:0]    trimmed;
	logic [atm_pkg::SUM_W-1:0]    shifted;

	// fold the sample into the burst statistics
	always_comb begin
		kept = position_q >= atm_pkg::POS_W'(SETTLE_SAMPLES);
		last = position_q >= atm_pkg::POS_W'(atm_pkg::BURST_LEN - 1);
		sum_n      = sum_q;
		largest_n  = largest_q;
		smallest_n = smallest_q;
		if (kept) begin
			sum_n = sum_q + atm_pkg::SUM_W'(sample);
			if (sample > largest_q) begin
				largest_n = sample;
			end
			if (sample < smallest_q) begin
				smallest_n = sample;
			end
		end
	end

	// drop max and min, scale, saturate to the sample range
	always_comb begin
		extremes = atm_pkg::SUM_W'(largest_n) + atm_pkg::SUM_W'(smallest_n);
		trimmed  = (sum_n >= extremes) ? (sum_n - extremes) : '0;
		shifted  = trimmed >> AVERAGE_SHIFT;
		res.done = last;
		if (|shifted[atm_pkg::SUM_W-1:atm_pkg::SAMPLE_W]) begin
			res.average = atm_pkg::SAMPLE_MAX;
		end else begin
			res.average = shifted[atm_pkg::SAMPLE_W-1:0];
		end
	end

	// burst state, cleared after the last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			sum_q      <= '0;
			largest_q  <= '0;
			smallest_q <= atm_pkg::SAMPLE_MAX;
		end else if (step) begin
			if (last) begin
				position_q <= '0;
				sum_q      <= '0;
				largest_q  <= '0;
				smallest_q <= atm_pkg::SAMPLE_MAX;
			end else begin
				position_q <= position_q + atm_pkg::POS_W'(1);
				sum_q      <= sum_n;
				largest_q  <= largest_n;
				smallest_q <= smallest_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/adc_burst_trimmed_mean.sv =====
// ----------------------------------------------------------------------------
// adc_burst_trimmed_mean
// trimmed mean over bursts of 20 converter samples
// ----------------------------------------------------------------------------
// Samples are grouped into bursts of 20. The first SETTLE_SAMPLES of each
// burst are dropped; the rest are summed while the largest and smallest are
// tracked. On the 20th sample the largest and smallest are taken off the sum,
// the difference is shifted right by AVERAGE_SHIFT, saturated to 12 bits and
// delivered as one average item; the other 19 samples give no item. The
// block takes one sample per cycle unless stalled: a sample is registered on
// acceptance, folded into the burst state by one add and two compares as it
// leaves the input register, and a finished average is registered in an
// output register. Input stalls only while an average waits unread and
// another sample is waiting in the input register.
`default_nettype none

module adc_burst_trimmed_mean #(
	parameter int SETTLE_SAMPLES = 2,
	parameter int AVERAGE_SHIFT  = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         sample_valid,
	output logic                              sample_ready,
	input  wire logic [atm_pkg::SAMPLE_W-1:0] sample,
	output logic                              average_valid,
	input  wire logic                         average_ready,
	output logic [atm_pkg::SAMPLE_W-1:0]      average
);

	logic                         valid_s1;
	logic [atm_pkg::SAMPLE_W-1:0] sample_s1;
	logic                         move_s1;
	atm_pkg::burst_res_t          res;

	// sample moves on when the output slot is free or being emptied
	assign move_s1      = valid_s1 && (!average_valid || average_ready);
	assign sample_ready = !valid_s1 || move_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	// burst statistics and trim
	atm_burst #(
		.SETTLE_SAMPLES(SETTLE_SAMPLES),
		.AVERAGE_SHIFT (AVERAGE_SHIFT)
	) u_burst (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (move_s1),
		.sample(sample_s1),
		.res   (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			average_valid <= 1'b0;
		end else if (move_s1 && res.done) begin
			average_valid <= 1'b1;
		end else if (average_ready) begin
			average_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && res.done) begin
			average <= res.average;
		end
	end

	// input stalls only behind a waiting average
	assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (valid_s1 && average_valid && !average_ready))
	else $error("input stalled without a blocked average");

	// closing sample always produces an item
	assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && res.done) |=> average_valid)
	else $error("closing sample gave no average");

	// an average appears only from a closing sample
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(average_valid) |-> $past(move_s1 && res.done))
	else $error("average without a closing sample");

endmodule

`default_nettype wire

// ===== bench/adc_burst_trimmed_mean_tb.sv =====
// ----------------------------------------------------------------------------
// adc_burst_trimmed_mean_tb
// self-checking bench for the burst trimmed-mean block
// ----------------------------------------------------------------------------
// Sends converter samples in whole bursts of 20 and keeps its own model of the
// burst state. The model drops the settling samples, sums the kept ones and
// tracks their largest and smallest value. When a burst closes it queues the
// expected average. Each average item from the block is compared in order
// with that queue. A directed burst at the sample extremes comes first. Then
// come random bursts of several shapes: flat, noisy, spiked, ramped, uniform
// and bursts with wild settling samples. Both sides stall at random in the
// first two phases. Neither side stalls in the last phase.
`default_nettype none

module adc_burst_trimmed_mean_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_SAMPLES = 2;
	localparam int AVERAGE_SHIFT  = 4;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int MAX_REPORTS    = 10;
	localparam int DRAIN_CYCLES   = 8;

	// shapes of a random burst
	typedef enum int {
		SHAPE_UNIFORM,
		SHAPE_FLAT,
		SHAPE_NOISY,
		SHAPE_SPIKED,
		SHAPE_WILD_SETTLE,
		SHAPE_RAMP
	} burst_shape_e;

	logic                         clk;
	logic                         arst_n;
	logic                         sample_valid;
	logic                         sample_ready;
	logic [atm_pkg::SAMPLE_W-1:0] sample;
	logic                         average_valid;
	logic                         average_ready;
	logic [atm_pkg::SAMPLE_W-1:0] average;

	// model of the burst state
	logic [atm_pkg::POS_W-1:0]    burst_pos;
	logic [atm_pkg::SUM_W-1:0]    kept_sum;
	logic [atm_pkg::SAMPLE_W-1:0] kept_max;
	logic [atm_pkg::SAMPLE_W-1:0] kept_min;

	logic [atm_pkg::SAMPLE_W-1:0] expected_averages[$];

	int send_idle_pct;
	int recv_idle_pct;
	int samples_sent;
	int averages_checked;
	int mismatch_count;
	int unexpected_count;
	int cycle_count;

	adc_burst_trimmed_mean #(
		.SETTLE_SAMPLES(SETTLE_SAMPLES),
		.AVERAGE_SHIFT (AVERAGE_SHIFT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.average_valid(average_valid),
		.average_ready(average_ready),
		.average      (average)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// cycle limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("simulation failed");
		$finish;
	end

	// receiver stalls
	always @(posedge clk) begin
		average_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// compare each average item with the oldest expectation
	always @(posedge clk) begin
		logic [atm_pkg::SAMPLE_W-1:0] want;
		if (arst_n && average_valid && average_ready) begin
			if (expected_averages.size() == 0) begin
				unexpected_count++;
				if (mismatch_count + unexpected_count <= MAX_REPORTS)
					$display("unexpected average item %0d", average);
			end else begin
				want = expected_averages.pop_front();
				averages_checked++;
				if (average !== want) begin
					mismatch_count++;
					if (mismatch_count + unexpected_count <= MAX_REPORTS)
						$display("average mismatch: expected %0d, got %0d", want, average);
				end
			end
		end
	end

	// fold one accepted sample into the model, queue an average on burst close
	task automatic fold_sample(input logic [atm_pkg::SAMPLE_W-1:0] s);
		logic                       closes;
		logic [atm_pkg::SAMPLE_W:0] extremes;
		logic [atm_pkg::SUM_W-1:0]  trimmed;
		logic [atm_pkg::SUM_W-1:0]  shifted;
		closes = (burst_pos >= atm_pkg::POS_W'(atm_pkg::BURST_LEN - 1));
		if (burst_pos >= atm_pkg::POS_W'(SETTLE_SAMPLES)) begin
			kept_sum = kept_sum + atm_pkg::SUM_W'(s);
			if (s > kept_max)
				kept_max = s;
			if (s < kept_min)
				kept_min = s;
		end
		if (!closes) begin
			burst_pos = burst_pos + atm_pkg::POS_W'(1);
		end else begin
			extremes = {1'b0, kept_max} + {1'b0, kept_min};
			if (kept_sum >= atm_pkg::SUM_W'(extremes))
				trimmed = kept_sum - atm_pkg::SUM_W'(extremes);
			else
				trimmed = '0;
			shifted = trimmed >> AVERAGE_SHIFT;
			if (shifted > atm_pkg::SUM_W'(atm_pkg::SAMPLE_MAX))
				expected_averages.push_back(atm_pkg::SAMPLE_MAX);
			else
				expected_averages.push_back(shifted[atm_pkg::SAMPLE_W-1:0]);
			burst_pos = '0;
			kept_sum  = '0;
			kept_max  = '0;
			kept_min  = atm_pkg::SAMPLE_MAX;
		end
	endtask

	// send one sample item; called and returns at a rising edge
	task automatic send_sample(input logic [atm_pkg::SAMPLE_W-1:0] s);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct)
				@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do
			@(posedge clk);
		while (!sample_ready);
		samples_sent++;
		fold_sample(s);
	endtask

	// one burst at the code extremes; the kept sum overflows 16 bits
	task automatic test_extreme_burst();
		send_sample('0);
		send_sample(atm_pkg::SAMPLE_MAX);
		send_sample('0);
		for (int i = 0; i < atm_pkg::BURST_LEN - SETTLE_SAMPLES - 1; i++)
			send_sample(atm_pkg::SAMPLE_MAX);
	endtask

	// random bursts of mixed shape
	task automatic test_random_bursts(input int n_bursts);
		burst_shape_e shape;
		int           level;
		int           spread;
		int           v;
		int           spike_a;
		int           spike_b;
		for (int b = 0; b < n_bursts; b++) begin
			shape   = burst_shape_e'($urandom_range(0, 5));
			spread  = $urandom_range(0, 40);
			spike_a = $urandom_range(SETTLE_SAMPLES, atm_pkg::BURST_LEN - 1);
			spike_b = $urandom_range(SETTLE_SAMPLES, atm_pkg::BURST_LEN - 1);
			case ($urandom_range(0, 3))
				0: level = 0;
				1: level = int'(atm_pkg::SAMPLE_MAX);
				default: level = $urandom_range(0, int'(atm_pkg::SAMPLE_MAX));
			endcase
			for (int i = 0; i < atm_pkg::BURST_LEN; i++) begin
				case (shape)
					SHAPE_FLAT: v = level;
					SHAPE_NOISY: v = level + $urandom_range(0, 2 * spread) - spread;
					SHAPE_SPIKED: begin
						if (i == spike_a)
							v = 0;
						else if (i == spike_b)
							v = int'(atm_pkg::SAMPLE_MAX);
						else
							v = level + $urandom_range(0, 2 * spread) - spread;
					end
					SHAPE_WILD_SETTLE: begin
						if (i < SETTLE_SAMPLES)
							v = $urandom_range(0, 1) ? int'(atm_pkg::SAMPLE_MAX) : 0;
						else
							v = level + $urandom_range(0, 2 * spread) - spread;
					end
					SHAPE_RAMP:
						v = (level + i * spread * 5) % (int'(atm_pkg::SAMPLE_MAX) + 1);
					default: v = $urandom_range(0, int'(atm_pkg::SAMPLE_MAX));
				endcase
				if (v < 0)
					v = 0;
				else if (v > int'(atm_pkg::SAMPLE_MAX))
					v = int'(atm_pkg::SAMPLE_MAX);
				send_sample(atm_pkg::SAMPLE_W'(v));
			end
		end
	endtask

	// test sequence
	initial begin
		arst_n           = 1'b0;
		sample_valid     = 1'b0;
		sample           = '0;
		burst_pos        = '0;
		kept_sum         = '0;
		kept_max         = '0;
		kept_min         = atm_pkg::SAMPLE_MAX;
		send_idle_pct    = 35;
		recv_idle_pct    = 47;
		samples_sent     = 0;
		averages_checked = 0;
		mismatch_count   = 0;
		unexpected_count = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_burst();
		test_random_bursts(17);

		send_idle_pct = 47;
		recv_idle_pct = 35;
		test_random_bursts(17);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_bursts(18);
		sample_valid <= 1'b0;

		while (expected_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d samples in %0d bursts, checked %0d averages",
			samples_sent, samples_sent / atm_pkg::BURST_LEN, averages_checked);
		$display("%0d mismatches, %0d unexpected items, %0d averages missing",
			mismatch_count, unexpected_count, expected_averages.size());
		if (mismatch_count == 0 && unexpected_count == 0 && expected_averages.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
